### src/smooth_step_curve_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the smooth step curve unit
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef SMOOTH_STEP_CURVE_UNIT_MACROS_SVH
`define SMOOTH_STEP_CURVE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smooth_step_curve_unit assertion failed");
`define SSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smooth_step_curve_unit assertion failed");
`else
`define SSC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/ssc_pkg.sv
// ----------------------------------------------------------------------------
// Smooth step curve unit package
// Shared control type and register index codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_EDGE_LOW   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EDGE_HIGH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CURVE_MODE = 2'd2;

    // Control that travels with every item down the pipeline.
    // fixed: t is known without division; one: that fixed t is 1.0, else 0.
    typedef struct packed {
        logic valid;
        logic mode;
        logic fixed;
        logic one;
    } ctrl_t;

endpackage

### src/ssc_div_cell.sv
// ----------------------------------------------------------------------------
// Restoring divider cell
// Produces one quotient bit per cell and hands the partial remainder on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssc_div_cell #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  ssc_pkg::ctrl_t           ctrl_in,
    input  logic [SAMPLE_BITS:0]     rem_in,
    input  logic [SAMPLE_BITS:0]     den_in,
    input  logic [FRACTION_BITS-1:0] quo_in,
    output ssc_pkg::ctrl_t           ctrl_out,
    output logic [SAMPLE_BITS:0]     rem_out,
    output logic [SAMPLE_BITS:0]     den_out,
    output logic [FRACTION_BITS-1:0] quo_out
);
    import ssc_pkg::*;

    ctrl_t                    ctrl_reg;
    logic [SAMPLE_BITS:0]     rem_reg;
    logic [SAMPLE_BITS:0]     den_reg;
    logic [FRACTION_BITS-1:0] quo_reg;

    logic [SAMPLE_BITS+1:0]   rem_dbl;
    logic [SAMPLE_BITS+1:0]   den_ext;
    logic [SAMPLE_BITS+1:0]   rem_sub;
    logic                     q_bit;
    logic [SAMPLE_BITS:0]     rem_next;

    always_comb
    begin
        rem_dbl  = {rem_in, 1'b0};
        den_ext  = {1'b0, den_in};
        rem_sub  = rem_dbl - den_ext;
        q_bit    = (rem_dbl >= den_ext);
        // The remainder stays below the divisor, so the low bits hold it.
        rem_next = q_bit ? rem_sub[SAMPLE_BITS:0] : rem_dbl[SAMPLE_BITS:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            quo_reg <= {quo_in[FRACTION_BITS-2:0], q_bit};
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign quo_out  = quo_reg;

endmodule

### src/ssc_poly.sv
// ----------------------------------------------------------------------------
// Curve polynomial pipeline
// Three multiplier stages evaluating the cubic or quintic curve of t.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssc_poly #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  ssc_pkg::ctrl_t         ctrl_in,
    input  logic [FRACTION_BITS:0] t_in,
    output logic                   valid_out,
    output logic [FRACTION_BITS:0] level_out
);
    import ssc_pkg::*;

    localparam int W = FRACTION_BITS + 4;
    localparam int P = 2 * W;
    localparam logic [W-1:0] ONE     = W'(1 << FRACTION_BITS);
    localparam logic [W-1:0] THREE   = W'(3 << FRACTION_BITS);
    localparam logic [W-1:0] TEN     = W'(10 << FRACTION_BITS);
    localparam logic [W-1:0] FIFTEEN = W'(15 << FRACTION_BITS);
    localparam logic [P-1:0] HALF    = P'(1 << (FRACTION_BITS - 1));

    ctrl_t                  a_ctrl_reg;
    logic [W-1:0]           a_t_reg;
    logic [W-1:0]           a_sq_reg;
    logic [W-1:0]           a_r_reg;
    ctrl_t                  b_ctrl_reg;
    logic [W-1:0]           b_m_reg;
    logic [W-1:0]           b_v_reg;
    logic                   c_valid_reg;
    logic [FRACTION_BITS:0] c_level_reg;

    logic [W-1:0] t_ext;
    logic [W-1:0] r_op;
    logic [P-1:0] sq_prod;
    logic [P-1:0] r_prod;
    logic [W-1:0] m_op;
    logic [P-1:0] m_prod;
    logic [P-1:0] y_prod;
    logic [W-1:0] y_val;

    // Every fraction product is rounded half up back to FRACTION_BITS.
    always_comb
    begin
        t_ext   = W'(t_in);
        r_op    = FIFTEEN - W'(6) * t_ext;
        sq_prod = P'(t_ext) * P'(t_ext) + HALF;
        r_prod  = P'(t_ext) * P'(r_op) + HALF;

        m_op    = a_ctrl_reg.mode ? a_t_reg : (THREE - {a_t_reg[W-2:0], 1'b0});
        m_prod  = P'(a_sq_reg) * P'(m_op) + HALF;

        y_prod  = P'(b_m_reg) * P'(b_v_reg) + HALF;
        y_val   = b_ctrl_reg.mode ? y_prod[FRACTION_BITS+W-1:FRACTION_BITS] : b_m_reg;
        if (y_val > ONE)
        begin
            y_val = ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctrl_reg  <= '0;
            b_ctrl_reg  <= '0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_ctrl_reg  <= ctrl_in;
            b_ctrl_reg  <= a_ctrl_reg;
            c_valid_reg <= b_ctrl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_t_reg     <= t_ext;
            a_sq_reg    <= sq_prod[FRACTION_BITS+W-1:FRACTION_BITS];
            a_r_reg     <= r_prod[FRACTION_BITS+W-1:FRACTION_BITS];
            b_m_reg     <= m_prod[FRACTION_BITS+W-1:FRACTION_BITS];
            b_v_reg     <= TEN - a_r_reg;
            c_level_reg <= y_val[FRACTION_BITS:0];
        end
    end

    assign valid_out = c_valid_reg;
    assign level_out = c_level_reg;

endmodule

### src/smooth_step_curve_unit.sv
// ----------------------------------------------------------------------------
// Smooth step curve unit
// Maps a Q8.8 sample onto the smoothstep or smootherstep curve between edges.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_axis    in         tdata: sample (signed Q8.8)
//  m_axis    out        tdata: level (unsigned Q1.16)
//  cfg       in         index 0 edge_low, 1 edge_high, 2 curve_mode
//
//  One sample is taken every clock while the output register is empty or taken;
//  it passes the input register, FRACTION_BITS divider cells of one quotient
//  bit each, and three multiplier stages.
//  The whole pipeline advances when the output register is empty or taken,
//  so a held result stalls the input only while it is not consumed.
//  Reset clears all valid flags and loads edge_low 0, edge_high 1.0, mode 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "smooth_step_curve_unit_macros.svh"

module smooth_step_curve_unit #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [SAMPLE_BITS-1:0] sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [FRACTION_BITS:0] level
    output logic [((FRACTION_BITS+8)/8)*8-1:0]     m_axis_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ssc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [SAMPLE_BITS-1:0]                 cfg_data
);
    import ssc_pkg::*;

    localparam int OUT_TDATA_W = ((FRACTION_BITS + 8) / 8) * 8;
    localparam logic [FRACTION_BITS:0] ONE = (FRACTION_BITS+1)'(1 << FRACTION_BITS);

    logic [SAMPLE_BITS-1:0] edge_low_reg;
    logic [SAMPLE_BITS-1:0] edge_high_reg;
    logic                   curve_mode_reg;

    logic                   en;
    logic [SAMPLE_BITS:0]   num;
    logic [SAMPLE_BITS:0]   den;
    logic [SAMPLE_BITS:0]   num_abs;
    logic [SAMPLE_BITS:0]   den_abs;
    ctrl_t                  in_ctrl_next;

    ctrl_t                    ctrl_chain [0:FRACTION_BITS];
    logic [SAMPLE_BITS:0]     rem_chain  [0:FRACTION_BITS];
    logic [SAMPLE_BITS:0]     den_chain  [0:FRACTION_BITS];
    logic [FRACTION_BITS-1:0] quo_chain  [0:FRACTION_BITS];

    logic [FRACTION_BITS:0] t_val;
    logic [FRACTION_BITS:0] level;

    logic                   div_head_busy;
    logic                   div_tail_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_low_reg   <= '0;
            edge_high_reg  <= SAMPLE_BITS'(256);
            curve_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_EDGE_LOW:   edge_low_reg   <= cfg_data;
                REG_EDGE_HIGH:  edge_high_reg  <= cfg_data;
                REG_CURVE_MODE: curve_mode_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Input stage: signed numerator and denominator, and the cases that
    // settle t without dividing.
    always_comb
    begin
        num     = {s_axis_tdata[SAMPLE_BITS-1], s_axis_tdata[SAMPLE_BITS-1:0]}
                - {edge_low_reg[SAMPLE_BITS-1], edge_low_reg};
        den     = {edge_high_reg[SAMPLE_BITS-1], edge_high_reg}
                - {edge_low_reg[SAMPLE_BITS-1], edge_low_reg};
        num_abs = num[SAMPLE_BITS] ? (~num + 1'b1) : num;
        den_abs = den[SAMPLE_BITS] ? (~den + 1'b1) : den;

        in_ctrl_next.valid = s_axis_tvalid;
        in_ctrl_next.mode  = curve_mode_reg;
        if (den == '0)
        begin
            in_ctrl_next.fixed = 1'b1;
            in_ctrl_next.one   = !num[SAMPLE_BITS];
        end
        else if ((num == '0) || (num[SAMPLE_BITS] != den[SAMPLE_BITS]))
        begin
            in_ctrl_next.fixed = 1'b1;
            in_ctrl_next.one   = 1'b0;
        end
        else if (num_abs >= den_abs)
        begin
            in_ctrl_next.fixed = 1'b1;
            in_ctrl_next.one   = 1'b1;
        end
        else
        begin
            in_ctrl_next.fixed = 1'b0;
            in_ctrl_next.one   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_chain[0] <= '0;
        end
        else if (en)
        begin
            ctrl_chain[0] <= in_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_chain[0] <= num_abs;
            den_chain[0] <= den_abs;
        end
    end

    assign quo_chain[0] = '0;

    for (genvar k = 0; k < FRACTION_BITS; k++)
    begin : g_div
        ssc_div_cell #(
            .SAMPLE_BITS   (SAMPLE_BITS),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctrl_in  (ctrl_chain[k]),
            .rem_in   (rem_chain[k]),
            .den_in   (den_chain[k]),
            .quo_in   (quo_chain[k]),
            .ctrl_out (ctrl_chain[k+1]),
            .rem_out  (rem_chain[k+1]),
            .den_out  (den_chain[k+1]),
            .quo_out  (quo_chain[k+1])
        );
    end

    always_comb
    begin
        if (ctrl_chain[FRACTION_BITS].fixed)
        begin
            t_val = ctrl_chain[FRACTION_BITS].one ? ONE : '0;
        end
        else
        begin
            t_val = {1'b0, quo_chain[FRACTION_BITS]};
        end
    end

    ssc_poly #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctrl_in   (ctrl_chain[FRACTION_BITS]),
        .t_in      (t_val),
        .valid_out (m_axis_tvalid),
        .level_out (level)
    );

    assign m_axis_tdata = OUT_TDATA_W'(level);

    // A divided item sits at the head or at the tail of the divider row.
    assign div_head_busy = ctrl_chain[0].valid && !ctrl_chain[0].fixed;
    assign div_tail_busy = ctrl_chain[FRACTION_BITS].valid && !ctrl_chain[FRACTION_BITS].fixed;

    `SSC_ASSERT_NOW(a_level_range, clk, rst_n, m_axis_tvalid, level <= ONE)
    `SSC_ASSERT_NOW(a_first_rem_below_den, clk, rst_n, div_head_busy, rem_chain[0] < den_chain[0])
    `SSC_ASSERT_NOW(a_last_rem_below_den, clk, rst_n, div_tail_busy, rem_chain[FRACTION_BITS] < den_chain[FRACTION_BITS])

endmodule
